>>> hw/rtl/dual_servo_motor_switch_overload_cut_unit_macros.svh
// Assertion macros shared by the servo switch RTL.
// No dependencies; included by the files that carry assertions.
`ifndef DUAL_SERVO_MOTOR_SWITCH_OVERLOAD_CUT_UNIT_MACROS_SVH
`define DUAL_SERVO_MOTOR_SWITCH_OVERLOAD_CUT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSMSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo switch assertion failed");

// Next-cycle implication, disabled during reset.
`define DSMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo switch assertion failed");

`endif

>>> hw/rtl/dsmsc_pkg.sv
// Shared constants, codes and types of the dual servo motor switch.
// No dependencies.
package dsmsc_pkg;

    localparam int COUNTER_BITS = 8;
    localparam int SENSE_BITS   = 10;
    localparam int THR_BITS     = 8;
    localparam int LIMIT_BITS   = 10;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 10;

    // compare widths cover both operands: the counter and the threshold, the sense and the limit
    localparam int CMP_BITS  = (COUNTER_BITS > THR_BITS) ? COUNTER_BITS : THR_BITS;
    localparam int SCMP_BITS = (SENSE_BITS > LIMIT_BITS) ? SENSE_BITS : LIMIT_BITS;

    typedef logic [COUNTER_BITS-1:0] count_t;
    typedef logic [SENSE_BITS-1:0]   sense_t;
    typedef logic [THR_BITS-1:0]     thr_t;
    typedef logic [LIMIT_BITS-1:0]   limit_t;
    typedef logic [1:0]              pos_t;
    typedef logic [1:0]              drv_t;

    localparam count_t COUNT_MAX = {COUNTER_BITS{1'b1}};

    localparam pos_t POS_INVALID = 2'd0;
    localparam pos_t POS_BACK    = 2'd1;
    localparam pos_t POS_NEUTRAL = 2'd2;
    localparam pos_t POS_FORWARD = 2'd3;

    localparam drv_t DRV_OFF = 2'd0;
    localparam drv_t DRV_CW  = 2'd1;
    localparam drv_t DRV_CCW = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_MIN         = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_BACK_UPPER  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_FWD_LOWER   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_MAX         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_ONE_MOTOR  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_TWO_MOTORS = 3'd5;

    typedef struct packed {
        thr_t tick_min;
        thr_t tick_back_upper;
        thr_t tick_fwd_lower;
        thr_t tick_max;
    } thr_cfg_t;

    typedef struct packed {
        limit_t one_motor;
        limit_t two_motors;
    } limit_cfg_t;

    typedef struct packed {
        drv_t drive_a;
        drv_t drive_b;
        logic cut_off;
        pos_t position_a;
        pos_t position_b;
    } result_t;

endpackage

>>> hw/rtl/dsmsc_lane.sv
// One servo channel: pulse width timer and position classifier.
// Depends on dsmsc_pkg.
module dsmsc_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                level,
    input  dsmsc_pkg::thr_cfg_t thr,
    output dsmsc_pkg::pos_t     position_next
);

    logic              prev_level_reg, prev_level_next;
    logic              running_reg, running_next;
    logic              overflow_reg, overflow_next;
    dsmsc_pkg::count_t ticks_reg, ticks_next;
    dsmsc_pkg::pos_t   position_reg;

    function automatic dsmsc_pkg::pos_t classify(input dsmsc_pkg::count_t n,
                                                 input dsmsc_pkg::thr_cfg_t t);
        logic [dsmsc_pkg::CMP_BITS-1:0] nx;
        dsmsc_pkg::pos_t p;
        nx = dsmsc_pkg::CMP_BITS'(n);
        priority if (nx > dsmsc_pkg::CMP_BITS'(t.tick_max))
            p = dsmsc_pkg::POS_INVALID;
        else if (nx > dsmsc_pkg::CMP_BITS'(t.tick_fwd_lower))
            p = dsmsc_pkg::POS_FORWARD;
        else if (nx > dsmsc_pkg::CMP_BITS'(t.tick_back_upper))
            p = dsmsc_pkg::POS_NEUTRAL;
        else if (nx > dsmsc_pkg::CMP_BITS'(t.tick_min))
            p = dsmsc_pkg::POS_BACK;
        else
            p = dsmsc_pkg::POS_INVALID;
        return p;
    endfunction

    always_comb
    begin
        prev_level_next = level;
        running_next    = running_reg;
        overflow_next   = overflow_reg;
        ticks_next      = ticks_reg;
        position_next   = position_reg;
        if (level && !prev_level_reg)
        begin
            ticks_next    = dsmsc_pkg::COUNTER_BITS'(1);
            overflow_next = 1'b0;
            running_next  = 1'b1;
        end
        else if (level && prev_level_reg && running_reg)
        begin
            if (ticks_reg == dsmsc_pkg::COUNT_MAX)
                overflow_next = 1'b1;
            ticks_next = ticks_reg + dsmsc_pkg::COUNTER_BITS'(1);
        end
        else if (!level && prev_level_reg && running_reg)
        begin
            // an overflowed pulse leaves the position alone
            if (!overflow_reg)
                position_next = classify(ticks_reg, thr);
            running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            running_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            ticks_reg      <= '0;
            position_reg   <= dsmsc_pkg::POS_NEUTRAL;
        end
        else if (step)
        begin
            prev_level_reg <= prev_level_next;
            running_reg    <= running_next;
            overflow_reg   <= overflow_next;
            ticks_reg      <= ticks_next;
            position_reg   <= position_next;
        end
    end

endmodule

>>> hw/rtl/dsmsc_merge.sv
// Merge stage: overcurrent trip, inhibit latch and motor drive decode.
// Depends on dsmsc_pkg.
module dsmsc_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  dsmsc_pkg::pos_t       pos_a,
    input  dsmsc_pkg::pos_t       pos_b,
    input  logic                  sense_valid,
    input  dsmsc_pkg::sense_t     sense_value,
    input  dsmsc_pkg::limit_cfg_t limits,
    output dsmsc_pkg::result_t    result
);

    dsmsc_pkg::drv_t drive_a_reg, drive_a_next;
    dsmsc_pkg::drv_t drive_b_reg, drive_b_next;
    logic            latch_reg, latch_next;

    logic            on_a, on_b, trip, latch_set;
    dsmsc_pkg::limit_t limit_sel;

    function automatic dsmsc_pkg::drv_t drive_for(input dsmsc_pkg::pos_t p);
        dsmsc_pkg::drv_t d;
        unique case (p)
            dsmsc_pkg::POS_BACK:    d = dsmsc_pkg::DRV_CCW;
            dsmsc_pkg::POS_FORWARD: d = dsmsc_pkg::DRV_CW;
            default:                d = dsmsc_pkg::DRV_OFF;
        endcase
        return d;
    endfunction

    always_comb
    begin
        on_a      = drive_a_reg != dsmsc_pkg::DRV_OFF;
        on_b      = drive_b_reg != dsmsc_pkg::DRV_OFF;
        limit_sel = (on_a && on_b) ? limits.two_motors : limits.one_motor;
        trip      = (on_a || on_b) && sense_valid &&
                    (dsmsc_pkg::SCMP_BITS'(sense_value) >
                     dsmsc_pkg::SCMP_BITS'(limit_sel));
        latch_set  = latch_reg || trip;
        // release once both sticks are back at neutral
        latch_next = latch_set && !(pos_a == dsmsc_pkg::POS_NEUTRAL &&
                                    pos_b == dsmsc_pkg::POS_NEUTRAL);
        if (latch_next)
        begin
            drive_a_next = dsmsc_pkg::DRV_OFF;
            drive_b_next = dsmsc_pkg::DRV_OFF;
        end
        else
        begin
            drive_a_next = drive_for(pos_a);
            drive_b_next = drive_for(pos_b);
        end
        result.drive_a    = drive_a_next;
        result.drive_b    = drive_b_next;
        result.cut_off    = latch_next;
        result.position_a = pos_a;
        result.position_b = pos_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_a_reg <= dsmsc_pkg::DRV_OFF;
            drive_b_reg <= dsmsc_pkg::DRV_OFF;
            latch_reg   <= 1'b0;
        end
        else if (step)
        begin
            drive_a_reg <= drive_a_next;
            drive_b_reg <= drive_b_next;
            latch_reg   <= latch_next;
        end
    end

endmodule

>>> hw/rtl/dual_servo_motor_switch_overload_cut_unit.sv
// An accepted result is registered in the output register, or in the skid entry on a stall.
// Throughput: one transaction per cycle while in_ready is high; the pulse timers,
// classifiers and trip/latch decode of the two lanes and merge stage are combinational.
// A two-entry output buffer keeps input accepted while one result is stalled.
// Reset: state and config registers return to their defaults, pin history reads
// high, positions neutral, drives off, latch clear; no clearing pass is needed.
// Top level of the dual servo motor switch; uses dsmsc_pkg, dsmsc_lane,
// dsmsc_merge and the assertion macro header.
`include "dual_servo_motor_switch_overload_cut_unit_macros.svh"

module dual_servo_motor_switch_overload_cut_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dsmsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [dsmsc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   level_a,
    input  logic                                   level_b,
    input  logic                                   sense_valid,
    input  logic [dsmsc_pkg::SENSE_BITS-1:0]       sense_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             drive_a,
    output logic [1:0]                             drive_b,
    output logic                                   cut_off,
    output logic [1:0]                             position_a,
    output logic [1:0]                             position_b
);

    dsmsc_pkg::thr_cfg_t   thr_reg;
    dsmsc_pkg::limit_cfg_t limit_reg;

    logic               in_fire;
    dsmsc_pkg::pos_t    pos_a_next, pos_b_next;
    dsmsc_pkg::result_t result;

    logic               out_valid_reg, skid_valid_reg;
    dsmsc_pkg::result_t out_data_reg, skid_data_reg;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.tick_min        <= 8'd31;
            thr_reg.tick_back_upper <= 8'd43;
            thr_reg.tick_fwd_lower  <= 8'd51;
            thr_reg.tick_max        <= 8'd63;
            limit_reg.one_motor     <= 10'd32;
            limit_reg.two_motors    <= 10'd40;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dsmsc_pkg::CFG_TICK_MIN:
                    thr_reg.tick_min <= cfg_data[dsmsc_pkg::THR_BITS-1:0];
                dsmsc_pkg::CFG_TICK_BACK_UPPER:
                    thr_reg.tick_back_upper <= cfg_data[dsmsc_pkg::THR_BITS-1:0];
                dsmsc_pkg::CFG_TICK_FWD_LOWER:
                    thr_reg.tick_fwd_lower <= cfg_data[dsmsc_pkg::THR_BITS-1:0];
                dsmsc_pkg::CFG_TICK_MAX:
                    thr_reg.tick_max <= cfg_data[dsmsc_pkg::THR_BITS-1:0];
                dsmsc_pkg::CFG_LIMIT_ONE_MOTOR:
                    limit_reg.one_motor <= cfg_data[dsmsc_pkg::LIMIT_BITS-1:0];
                dsmsc_pkg::CFG_LIMIT_TWO_MOTORS:
                    limit_reg.two_motors <= cfg_data[dsmsc_pkg::LIMIT_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    dsmsc_lane u_lane_a (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_fire),
        .level         (level_a),
        .thr           (thr_reg),
        .position_next (pos_a_next)
    );

    dsmsc_lane u_lane_b (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_fire),
        .level         (level_b),
        .thr           (thr_reg),
        .position_next (pos_b_next)
    );

    dsmsc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_fire),
        .pos_a       (pos_a_next),
        .pos_b       (pos_b_next),
        .sense_valid (sense_valid),
        .sense_value (sense_value),
        .limits      (limit_reg),
        .result      (result)
    );

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire)
                out_data_reg <= result;
        end
        else if (in_fire)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive_a    = out_data_reg.drive_a;
    assign drive_b    = out_data_reg.drive_b;
    assign cut_off    = out_data_reg.cut_off;
    assign position_a = out_data_reg.position_a;
    assign position_b = out_data_reg.position_b;

    `DSMSC_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `DSMSC_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
        in_fire && out_valid_reg && !out_ready, skid_valid_reg && out_valid_reg)
    `DSMSC_ASSERT_NOW(a_cut_means_off, clk, rst_n, out_valid_reg && out_data_reg.cut_off,
        out_data_reg.drive_a == dsmsc_pkg::DRV_OFF && out_data_reg.drive_b == dsmsc_pkg::DRV_OFF)

endmodule

>>> tb/testbench.sv
// Self-checking bench for the dual servo motor switch with overcurrent trip.
// Drives pin-level ticks over valid/ready and predicts every switch output.
// Depends on dsmsc_pkg and the dual_servo_motor_switch_overload_cut_unit top.
module testbench;

    // indexes past the register list; writes there must change nothing
    localparam logic [dsmsc_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [dsmsc_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {RX_STREAM, RX_COIN, RX_CHOKE, RX_COMB} rx_mode_t;

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                cfg_we      = 1'b0;
    logic [dsmsc_pkg::CFG_IDX_BITS-1:0]  cfg_index   = '0;
    logic [dsmsc_pkg::CFG_DATA_BITS-1:0] cfg_data    = '0;
    logic                                in_valid    = 1'b0;
    logic                                in_ready;
    logic                                level_a     = 1'b0;
    logic                                level_b     = 1'b0;
    logic                                sense_valid = 1'b0;
    dsmsc_pkg::sense_t                   sense_value = '0;
    logic                                out_valid;
    logic                                out_ready   = 1'b0;
    logic [1:0]                          drive_a;
    logic [1:0]                          drive_b;
    logic                                cut_off;
    logic [1:0]                          position_a;
    logic [1:0]                          position_b;

    dual_servo_motor_switch_overload_cut_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .level_a     (level_a),
        .level_b     (level_b),
        .sense_valid (sense_valid),
        .sense_value (sense_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_a     (drive_a),
        .drive_b     (drive_b),
        .cut_off     (cut_off),
        .position_a  (position_a),
        .position_b  (position_b)
    );

    always #10 clk = ~clk;

    // switch state as the block should hold it
    dsmsc_pkg::thr_t   thr_min, thr_back, thr_fwd, thr_max;
    dsmsc_pkg::limit_t lim_one, lim_two;
    logic              prev_lvl [2];
    logic              running  [2];
    dsmsc_pkg::count_t ticks    [2];
    logic              wrapped  [2];
    dsmsc_pkg::pos_t   chan_pos [2];
    dsmsc_pkg::drv_t   drv      [2];
    logic              latch;

    dsmsc_pkg::result_t predicted_outputs [$];
    dsmsc_pkg::result_t due_result;

    int fail_count    = 0;
    int tick_count    = 0;
    int checked_count = 0;
    int config_count  = 0;
    int trip_count    = 0;
    int discard_count = 0;

    int burst_left = 0;
    bit gaps_on    = 1'b1;
    int hi_left [2] = '{0, 0};
    int lo_left [2] = '{0, 0};

    rx_mode_t rx_mode  = RX_STREAM;
    int       rx_left  = 0;
    int       rx_cycle = 0;

    function automatic dsmsc_pkg::pos_t classify_count(dsmsc_pkg::count_t n);
        if (n > thr_max) return dsmsc_pkg::POS_INVALID;
        if (n > thr_fwd) return dsmsc_pkg::POS_FORWARD;
        if (n > thr_back) return dsmsc_pkg::POS_NEUTRAL;
        if (n > thr_min) return dsmsc_pkg::POS_BACK;
        return dsmsc_pkg::POS_INVALID;
    endfunction

    function automatic dsmsc_pkg::drv_t drive_of(dsmsc_pkg::pos_t p);
        if (p == dsmsc_pkg::POS_BACK) return dsmsc_pkg::DRV_CCW;
        if (p == dsmsc_pkg::POS_FORWARD) return dsmsc_pkg::DRV_CW;
        return dsmsc_pkg::DRV_OFF;
    endfunction

    function automatic dsmsc_pkg::result_t next_switch_outputs(logic la, logic lb,
                                                               logic sv,
                                                               dsmsc_pkg::sense_t sval);
        dsmsc_pkg::result_t r;
        logic               lv [2];
        logic               on_a, on_b;
        dsmsc_pkg::limit_t  lim;
        lv[0] = la;
        lv[1] = lb;
        for (int ch = 0; ch < 2; ch++)
        begin
            if (lv[ch] && !prev_lvl[ch])
            begin
                ticks[ch]   = 1;
                wrapped[ch] = 1'b0;
                running[ch] = 1'b1;
            end
            else if (lv[ch] && prev_lvl[ch])
            begin
                if (running[ch])
                begin
                    if (ticks[ch] == dsmsc_pkg::COUNT_MAX) wrapped[ch] = 1'b1;
                    ticks[ch] = ticks[ch] + 1'b1;
                end
            end
            else if (!lv[ch] && prev_lvl[ch])
            begin
                if (running[ch])
                begin
                    if (!wrapped[ch]) chan_pos[ch] = classify_count(ticks[ch]);
                    else discard_count++;
                    running[ch] = 1'b0;
                end
            end
            prev_lvl[ch] = lv[ch];
        end
        // limit follows the drives of the previous tick
        on_a = (drv[0] != dsmsc_pkg::DRV_OFF);
        on_b = (drv[1] != dsmsc_pkg::DRV_OFF);
        if ((on_a || on_b) && sv)
        begin
            lim = (on_a && on_b) ? lim_two : lim_one;
            if (sval > lim)
            begin
                drv[0] = dsmsc_pkg::DRV_OFF;
                drv[1] = dsmsc_pkg::DRV_OFF;
                latch  = 1'b1;
                trip_count++;
            end
        end
        if (latch && chan_pos[0] == dsmsc_pkg::POS_NEUTRAL &&
            chan_pos[1] == dsmsc_pkg::POS_NEUTRAL)
            latch = 1'b0;
        if (!latch)
        begin
            drv[0] = drive_of(chan_pos[0]);
            drv[1] = drive_of(chan_pos[1]);
        end
        r.drive_a    = drv[0];
        r.drive_b    = drv[1];
        r.cut_off    = latch;
        r.position_a = chan_pos[0];
        r.position_b = chan_pos[1];
        return r;
    endfunction

    task automatic load_reset_state();
        thr_min  = 8'd31;
        thr_back = 8'd43;
        thr_fwd  = 8'd51;
        thr_max  = 8'd63;
        lim_one  = 10'd32;
        lim_two  = 10'd40;
        for (int ch = 0; ch < 2; ch++)
        begin
            prev_lvl[ch] = 1'b1;
            running[ch]  = 1'b0;
            ticks[ch]    = '0;
            wrapped[ch]  = 1'b0;
            chan_pos[ch] = dsmsc_pkg::POS_NEUTRAL;
            drv[ch]      = dsmsc_pkg::DRV_OFF;
        end
        latch = 1'b0;
    endtask

    // one tick per transaction; the sender runs in bursts with gaps between
    task automatic send_tick(input logic la, input logic lb, input logic sv,
                             input dsmsc_pkg::sense_t sval);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        level_a     <= la;
        level_b     <= lb;
        sense_valid <= sv;
        sense_value <= sval;
        do @(posedge clk); while (!in_ready);
        predicted_outputs.push_back(next_switch_outputs(la, lb, sv, sval));
        tick_count++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dsmsc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [dsmsc_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dsmsc_pkg::CFG_TICK_MIN:         thr_min  = data[dsmsc_pkg::THR_BITS-1:0];
            dsmsc_pkg::CFG_TICK_BACK_UPPER:  thr_back = data[dsmsc_pkg::THR_BITS-1:0];
            dsmsc_pkg::CFG_TICK_FWD_LOWER:   thr_fwd  = data[dsmsc_pkg::THR_BITS-1:0];
            dsmsc_pkg::CFG_TICK_MAX:         thr_max  = data[dsmsc_pkg::THR_BITS-1:0];
            dsmsc_pkg::CFG_LIMIT_ONE_MOTOR:  lim_one  = data[dsmsc_pkg::LIMIT_BITS-1:0];
            dsmsc_pkg::CFG_LIMIT_TWO_MOTORS: lim_two  = data[dsmsc_pkg::LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [dsmsc_pkg::CFG_DATA_BITS-1:0] tmin, tback,
                              input logic [dsmsc_pkg::CFG_DATA_BITS-1:0] tfwd, tmax,
                              input logic [dsmsc_pkg::CFG_DATA_BITS-1:0] lone, ltwo);
        drain_results();
        write_reg(dsmsc_pkg::CFG_TICK_MIN, tmin);
        write_reg(dsmsc_pkg::CFG_TICK_BACK_UPPER, tback);
        write_reg(dsmsc_pkg::CFG_TICK_FWD_LOWER, tfwd);
        write_reg(dsmsc_pkg::CFG_TICK_MAX, tmax);
        write_reg(dsmsc_pkg::CFG_LIMIT_ONE_MOTOR, lone);
        write_reg(dsmsc_pkg::CFG_LIMIT_TWO_MOTORS, ltwo);
        config_count++;
    endtask

    // both pins high for their lengths, then one tick with both low
    task automatic send_pulse_pair(input int len_a, input int len_b);
        int span;
        span = (len_a > len_b) ? len_a : len_b;
        for (int i = 0; i < span; i++)
            send_tick(i < len_a, i < len_b, 1'b0,
                      dsmsc_pkg::sense_t'($urandom_range(0, 1023)));
        send_tick(1'b0, 1'b0, 1'b0, dsmsc_pkg::sense_t'($urandom_range(0, 1023)));
    endtask

    task automatic send_sample(input logic sv, input int value);
        send_tick(1'b0, 1'b0, sv, dsmsc_pkg::sense_t'(value));
    endtask

    function automatic int pick_pulse_len();
        int base;
        case ($urandom_range(0, 11))
            0:       base = int'(thr_min);
            1:       base = int'(thr_min) + 1;
            2:       base = int'(thr_back);
            3:       base = int'(thr_back) + 1;
            4:       base = int'(thr_fwd);
            5:       base = int'(thr_fwd) + 1;
            6:       base = int'(thr_max);
            7:       base = int'(thr_max) + 1;
            8:       base = $urandom_range(1, int'(thr_max) + 2);
            default: base = $urandom_range(1, 6);
        endcase
        return (base < 1) ? 1 : base;
    endfunction

    function automatic dsmsc_pkg::sense_t pick_sample();
        int v;
        if ($urandom_range(0, 1)) return dsmsc_pkg::sense_t'($urandom_range(0, 1023));
        v = ($urandom_range(0, 1) ? int'(lim_one) : int'(lim_two))
            + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return dsmsc_pkg::sense_t'(v);
    endfunction

    // well-formed pulse trains on both pins, with the odd glitch
    task automatic run_random_phase(input int n_items);
        logic lv [2];
        for (int i = 0; i < n_items; i++)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                if (hi_left[ch] == 0 && lo_left[ch] == 0)
                begin
                    hi_left[ch] = pick_pulse_len();
                    lo_left[ch] = $urandom_range(1, 4);
                end
                if (hi_left[ch] > 0)
                begin
                    lv[ch] = 1'b1;
                    hi_left[ch]--;
                end
                else
                begin
                    lv[ch] = 1'b0;
                    lo_left[ch]--;
                end
                if ($urandom_range(0, 19) == 0) lv[ch] = ~lv[ch];
            end
            send_tick(lv[0], lv[1], 1'b1 & $urandom_range(0, 1), pick_sample());
        end
    endtask

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                fail_count++;
            end
            else
            begin
                due_result = predicted_outputs.pop_front();
                check_field("drive_a", due_result.drive_a, drive_a);
                check_field("drive_b", due_result.drive_b, drive_b);
                check_field("cut_off", {1'b0, due_result.cut_off}, {1'b0, cut_off});
                check_field("position_a", due_result.position_a, position_a);
                check_field("position_b", due_result.position_b, position_b);
                checked_count++;
            end
        end
    end

    // receiver backpressure: modes of random length
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 150);
        end
        rx_left--;
        rx_cycle++;
        case (rx_mode)
            RX_STREAM: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'b1 & $urandom_range(0, 1);
            RX_CHOKE:  out_ready <= ($urandom_range(0, 5) == 0);
            default:   out_ready <= ((rx_cycle % 4) != 3);
        endcase
    end

    // reset values in force: no edge from the high pin history, then defaults
    task automatic test_reset_defaults();
        repeat (3) send_tick(1'b1, 1'b1, 1'b0, '0);
        send_tick(1'b0, 1'b0, 1'b1, 10'h3FF);
        send_tick(1'b0, 1'b0, 1'b0, '0);
        send_pulse_pair(52, 44);
        send_sample(1'b1, 32);
        send_sample(1'b1, 33);
        send_pulse_pair(44, 0);
    endtask

    task automatic test_short_classes();
        set_config(1, 3, 5, 7, 100, 200);
        for (int len = 1; len <= 8; len++)
            send_pulse_pair(len, 9 - len);
    endtask

    task automatic test_overload_latch();
        set_config(1, 3, 5, 7, 100, 200);
        send_pulse_pair(6, 2);
        send_sample(1'b1, 200);
        send_sample(1'b1, 201);
        send_sample(1'b1, 1023);
        send_pulse_pair(4, 0);
        send_pulse_pair(0, 4);
        send_pulse_pair(2, 0);
        send_sample(1'b1, 100);
        send_sample(1'b1, 101);
        send_sample(1'b0, 1023);
        send_pulse_pair(4, 0);
        send_pulse_pair(8, 7);
        send_sample(1'b0, 1023);
        send_sample(1'b1, 0);
        send_pulse_pair(1, 1);
        send_sample(1'b1, 1023);
    endtask

    // upper data bits of a threshold write fall away; A wraps, B stops one short
    task automatic test_counter_wrap();
        set_config(10, 20, 254, 10'h3FF, 1023, 1023);
        send_pulse_pair(256, 255);
        send_pulse_pair(21, 15);
    endtask

    task automatic test_unordered_thresholds();
        set_config(6, 2, 9, 12, 5, 1000);
        write_reg(CFG_SPARE_LO, 10'h3FF);
        write_reg(CFG_SPARE_HI, 10'h000);
        for (int len = 1; len <= 13; len++)
            send_pulse_pair(len, 14 - len);
    endtask

    task automatic test_random_traffic();
        set_config(2, 5, 8, 11, 10, 20);
        run_random_phase(20);
        set_config(31, 43, 51, 63, 32, 40);
        run_random_phase(20);
        set_config(0, 0, 0, 255, 1023, 0);
        run_random_phase(15);
        set_config(255, 255, 255, 255, 0, 1023);
        run_random_phase(15);
        gaps_on = 1'b0;
        repeat (2)
        begin
            set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
            run_random_phase(15);
        end
        gaps_on = 1'b1;
        set_config(3, 6, 9, 12, 512, 600);
        run_random_phase(15);
    endtask

    initial
    begin
        load_reset_state();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_short_classes();
        test_overload_latch();
        test_counter_wrap();
        test_unordered_thresholds();
        test_random_traffic();
        drain_results();
        repeat (5) @(posedge clk);
        $display("%0d ticks sent, %0d results compared, %0d register settings",
                 tick_count, checked_count, config_count);
        $display("%0d overload trips and %0d overflowed pulses seen", trip_count,
                 discard_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(20 * 500000);
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/dsmsc_pkg.sv
hw/rtl/dsmsc_lane.sv
hw/rtl/dsmsc_merge.sv
hw/rtl/dual_servo_motor_switch_overload_cut_unit.sv
tb/testbench.sv
